@@ rtl/aer_eda_pkg.sv @@
// Shared types, constants and helper functions for the address-event decoder.
package aer_eda_pkg;

  localparam int SENSOR_SIZE = 128;
  localparam int PIXEL_WIDTH = 16;

  localparam int COORD_W     = $clog2(SENSOR_SIZE);
  localparam int FRAME_CELLS = SENSOR_SIZE * SENSOR_SIZE;
  localparam int ADDR_W      = $clog2(FRAME_CELLS);
  localparam int TS_W        = 14;
  localparam int OFFSET_W    = 32 - TS_W;
  localparam int PV_W        = 16;

  localparam logic signed [PIXEL_WIDTH-1:0] PIX_MAX = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
  localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

  // Bit positions inside the sensor word.
  localparam int WRAP_BIT  = 31;
  localparam int RESET_BIT = 30;

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_WRAP  = 2'd1,
    KIND_RESET = 2'd2
  } word_kind_t;

  typedef struct packed {
    word_kind_t               word_kind;
    logic [6:0]               x_coord;
    logic [6:0]               y_coord;
    logic                     is_on;
    logic [31:0]              event_time;
    logic                     accepted;
    logic signed [PV_W-1:0]   pixel_value;
    logic                     ends_packet;
  } result_t;

  // Low 16 bits of a frame counter, sign-extended first when it is narrower.
  function automatic logic signed [PV_W-1:0] pix_to_pv(input logic signed [PIXEL_WIDTH-1:0] v);
    logic signed [31:0] ext;
    begin
      ext = 32'(v);
      return ext[PV_W-1:0];
    end
  endfunction

endpackage

@@ rtl/aer_event_decode_accumulate.sv @@
// Top level: address-event word decoder with a saturating per-pixel frame store.
// Results go from the stage 1 registers through an output queue to the out_ channel.
// Throughput: one request per cycle unless the output queue fills; each address event does
// one read-modify-write of the frame RAM (read at accept, write in the next cycle through
// the single write port). Reset: wrap offset cleared at once; then a clearing pass writes
// zero to all 16384 frame entries, one per cycle, during which in_ready stays low.
module aer_event_decode_accumulate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_aer_word,
  input  logic               in_packet_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_word_kind,
  output logic [6:0]         out_x_coord,
  output logic [6:0]         out_y_coord,
  output logic               out_is_on,
  output logic [31:0]        out_event_time,
  output logic               out_accepted,
  output logic signed [15:0] out_pixel_value,
  output logic               out_ends_packet
);

  localparam int AW = aer_eda_pkg::ADDR_W;
  localparam int PW = aer_eda_pkg::PIXEL_WIDTH;

  // ---------------------------------------------------------------------------
  // Clearing pass after reset. The top bit of the counter marks completion.
  // ---------------------------------------------------------------------------
  logic [AW:0] clr_cnt_r;
  logic        clearing;

  assign clearing = !clr_cnt_r[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode. The word is decoded at accept time; the frame RAM read is
  // issued at the same edge so the stored count arrives in stage 1.
  // ---------------------------------------------------------------------------
  logic                                  in_fire;
  logic                                  is_wrap;
  logic                                  is_rst;
  logic [aer_eda_pkg::COORD_W-1:0]       dec_x;
  logic [aer_eda_pkg::COORD_W-1:0]       dec_y;
  logic [AW-1:0]                         dec_addr;
  logic                                  dec_stuck;
  logic [aer_eda_pkg::OFFSET_W-1:0]      wrap_off_r;
  logic [aer_eda_pkg::OFFSET_W-1:0]      wrap_off_nxt;

  assign in_fire = in_valid && in_ready;
  assign is_wrap = in_aer_word[aer_eda_pkg::WRAP_BIT];
  assign is_rst  = !is_wrap && in_aer_word[aer_eda_pkg::RESET_BIT];

  // The column is mirrored: 127 minus a 7-bit field is its complement.
  assign dec_x     = ~in_aer_word[7:1];
  assign dec_y     = in_aer_word[14:8];
  assign dec_addr  = {dec_y, dec_x};
  assign dec_stuck = (dec_x == '1) && (dec_y == '0);

  always_comb begin
    wrap_off_nxt = wrap_off_r;
    if (in_fire) begin
      if (is_wrap) begin
        wrap_off_nxt = wrap_off_r + 1'b1;
      end else if (is_rst) begin
        wrap_off_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_off_r <= '0;
    end else begin
      wrap_off_r <= wrap_off_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: the decoded request waiting for its RAM data.
  // ---------------------------------------------------------------------------
  logic                   s1_vld_r;
  aer_eda_pkg::result_t   s1_res_r;
  logic                   s1_upd_r;
  logic [AW-1:0]          s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r            <= dec_addr;
      s1_res_r.ends_packet <= in_packet_end;
      s1_res_r.accepted    <= 1'b0;
      s1_res_r.pixel_value <= '0;
      if (is_wrap) begin
        s1_upd_r            <= 1'b0;
        s1_res_r.word_kind  <= aer_eda_pkg::KIND_WRAP;
        s1_res_r.x_coord    <= '0;
        s1_res_r.y_coord    <= '0;
        s1_res_r.is_on      <= 1'b0;
        s1_res_r.event_time <= '0;
      end else if (is_rst) begin
        s1_upd_r            <= 1'b0;
        s1_res_r.word_kind  <= aer_eda_pkg::KIND_RESET;
        s1_res_r.x_coord    <= '0;
        s1_res_r.y_coord    <= '0;
        s1_res_r.is_on      <= 1'b0;
        s1_res_r.event_time <= '0;
      end else begin
        s1_upd_r            <= !dec_stuck;
        s1_res_r.word_kind  <= aer_eda_pkg::KIND_ADDR;
        s1_res_r.x_coord    <= dec_x;
        s1_res_r.y_coord    <= dec_y;
        s1_res_r.is_on      <= in_aer_word[0];
        // The offset counts 0x4000 steps, so offset plus the 14-bit stamp
        // is a plain concatenation; it wraps modulo 2^32 with the counter.
        s1_res_r.event_time <= {wrap_off_r, in_aer_word[29:16]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame RAM and the read-modify-write in stage 1.
  // ---------------------------------------------------------------------------
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [PW-1:0]          ram_wdata;
  logic [PW-1:0]          ram_rdata;
  logic                   s1_we;
  logic signed [PW-1:0]   old_val;
  logic signed [PW-1:0]   new_val;

  // Forwarding: the write done at the edge where this request read the RAM
  // is not visible in the read data, so it is held here for the request in stage 1.
  logic                   fwd_vld_r;
  logic [AW-1:0]          fwd_addr_r;
  logic signed [PW-1:0]   fwd_data_r;

  assign s1_we = s1_vld_r && s1_upd_r;

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_addr_r)) begin
      old_val = fwd_data_r;
    end else begin
      old_val = $signed(ram_rdata);
    end
    if (s1_res_r.is_on) begin
      new_val = (old_val == aer_eda_pkg::PIX_MAX) ? old_val : old_val + 1'b1;
    end else begin
      new_val = (old_val == aer_eda_pkg::PIX_MIN) ? old_val : old_val - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= s1_we;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_val;
    end
  end

  // The clearing pass owns the write port while no request can be in flight.
  assign ram_we    = clearing || s1_we;
  assign ram_waddr = clearing ? clr_cnt_r[AW-1:0] : s1_addr_r;
  assign ram_wdata = clearing ? '0 : new_val;

  aer_eda_ram #(
    .WIDTH (PW),
    .DEPTH (aer_eda_pkg::FRAME_CELLS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (dec_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output queue of three entries. A request is taken only when the queue
  // plus stage 1 hold at most two, so a finished result always has a slot.
  // ---------------------------------------------------------------------------
  aer_eda_pkg::result_t   s1_out;
  aer_eda_pkg::result_t   q_mem_r [3];
  logic [1:0]             q_wr_r;
  logic [1:0]             q_rd_r;
  logic [1:0]             q_cnt_r;
  logic                   q_push;
  logic                   q_pop;
  logic [2:0]             q_load;
  aer_eda_pkg::result_t   q_head;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    begin
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
    end
  endfunction

  always_comb begin
    s1_out = s1_res_r;
    if (s1_upd_r) begin
      s1_out.accepted    = 1'b1;
      s1_out.pixel_value = aer_eda_pkg::pix_to_pv(new_val);
    end
  end

  assign q_push   = s1_vld_r;
  assign q_pop    = out_valid && out_ready;
  assign q_load   = {1'b0, q_cnt_r} + {2'b00, s1_vld_r};
  assign in_ready = !clearing && (q_load <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= ptr_inc(q_wr_r);
      end
      if (q_pop) begin
        q_rd_r <= ptr_inc(q_rd_r);
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= s1_out;
    end
  end

  assign q_head          = q_mem_r[q_rd_r];
  assign out_valid       = (q_cnt_r != 2'd0);
  assign out_word_kind   = q_head.word_kind;
  assign out_x_coord     = q_head.x_coord;
  assign out_y_coord     = q_head.y_coord;
  assign out_is_on       = q_head.is_on;
  assign out_event_time  = q_head.event_time;
  assign out_accepted    = q_head.accepted;
  assign out_pixel_value = q_head.pixel_value;
  assign out_ends_packet = q_head.ends_packet;

`ifndef SYNTHESIS
  // A finished request must always find room in the output queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (q_cnt_r != 2'd3) || q_pop)
    else $error("output queue overflow");

  // No request is taken while the frame store is still being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready && !s1_vld_r)
    else $error("request accepted during clearing pass");

  // Stage 1 holds exactly the request accepted in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted request lost before stage 1");

  // A frame update never changes a counter by more than one step.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_we |-> (new_val == old_val) || (new_val == old_val + 1'b1) ||
              (new_val == old_val - 1'b1))
    else $error("frame update out of range");
`endif

endmodule

@@ rtl/aer_eda_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module aer_eda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ bench/tb_aer_event_decode_accumulate.sv @@
// Self-checking testbench for the address-event decoder with its accumulating frame store.
module tb_aer_event_decode_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  // Guard time for the whole run. A correct run (clearing pass plus about 1400 requests
  // under the idle patterns) takes roughly 80 us here.
  localparam int RUN_LIMIT_NS = 1_000_000;
  // The block passes each request through stage 1 into its output queue, so a short drain is plenty.
  localparam int DRAIN_CYCLES = 1000;
  localparam int SHOW_LIMIT   = 10;

  // One request on the input channel: a sensor word and its end-of-packet mark.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } aer_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_aer_word = '0;
  logic        in_packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_word_kind;
  logic [6:0]  out_x_coord;
  logic [6:0]  out_y_coord;
  logic        out_is_on;
  logic [31:0] out_event_time;
  logic        out_accepted;
  logic signed [15:0] out_pixel_value;
  logic        out_ends_packet;

  aer_event_decode_accumulate DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_aer_word     (in_aer_word),
    .in_packet_end   (in_packet_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_kind   (out_word_kind),
    .out_x_coord     (out_x_coord),
    .out_y_coord     (out_y_coord),
    .out_is_on       (out_is_on),
    .out_event_time  (out_event_time),
    .out_accepted    (out_accepted),
    .out_pixel_value (out_pixel_value),
    .out_ends_packet (out_ends_packet)
  );

  // 4 ns period: two delays, low then high.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting to be driven, and decoded results waiting to come out.
  aer_req_t              aer_req_q[$];
  aer_eda_pkg::result_t  decoded_q[$];

  // Our own copy of the block's state: the frame counters and the wrap step count.
  logic signed [aer_eda_pkg::PIXEL_WIDTH-1:0] frame_count [aer_eda_pkg::FRAME_CELLS];
  logic [aer_eda_pkg::OFFSET_W-1:0]           wrap_steps = '0;

  // Idle chances in percent for the sender and the receiver, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Handshake seen at the last rising edge, for the driver at the next falling edge.
  logic in_hs = 1'b0;

  int unsigned queued_reqs = 0;
  int unsigned taken_reqs = 0;
  int unsigned checked_results = 0;
  int unsigned error_count = 0;
  int unsigned shown_errors = 0;

  // What the run went through, reported at the end.
  int unsigned seen_addr = 0;
  int unsigned seen_stuck = 0;
  int unsigned seen_wrap = 0;
  int unsigned seen_reset = 0;
  int unsigned seen_clamped = 0;
  int unsigned seen_rollover = 0;

  // Decode one sensor word and apply it to the frame copy, exactly as the block must.
  // Bit 31 wins over bit 30, so a word with both set counts as a wrap.
  function automatic aer_eda_pkg::result_t decode_word(input logic [31:0] w,
                                                       input logic last);
    aer_eda_pkg::result_t r;
    logic [6:0] px;
    logic [6:0] py;
    logic [aer_eda_pkg::ADDR_W-1:0] pix_idx;
    logic signed [aer_eda_pkg::PIXEL_WIDTH-1:0] v;
    r = '0;
    r.ends_packet = last;
    if (w[aer_eda_pkg::WRAP_BIT]) begin
      r.word_kind = aer_eda_pkg::KIND_WRAP;
      seen_wrap++;
      // The step count is 18 bits wide and simply rolls over to zero.
      if (wrap_steps == '1) begin
        seen_rollover++;
      end
      wrap_steps = wrap_steps + 1'b1;
    end else if (w[aer_eda_pkg::RESET_BIT]) begin
      r.word_kind = aer_eda_pkg::KIND_RESET;
      seen_reset++;
      wrap_steps = '0;
    end else begin
      // The column is mirrored: x = 127 - bits 7:1, which is their complement.
      px = ~w[7:1];
      py = w[14:8];
      r.word_kind = aer_eda_pkg::KIND_ADDR;
      r.x_coord = px;
      r.y_coord = py;
      r.is_on = w[0];
      r.event_time = {wrap_steps, {aer_eda_pkg::TS_W{1'b0}}} +
                     {{aer_eda_pkg::OFFSET_W{1'b0}}, w[29:16]};
      seen_addr++;
      if (px == 7'd127 && py == 7'd0) begin
        // The stuck pixel reports its event but never touches the store.
        seen_stuck++;
      end else begin
        pix_idx = {py, px};
        v = frame_count[pix_idx];
        if (w[0]) begin
          if (v != aer_eda_pkg::PIX_MAX) begin
            v = v + 1'b1;
          end else begin
            seen_clamped++;
          end
        end else begin
          if (v != aer_eda_pkg::PIX_MIN) begin
            v = v - 1'b1;
          end else begin
            seen_clamped++;
          end
        end
        frame_count[pix_idx] = v;
        r.accepted = 1'b1;
        r.pixel_value = aer_eda_pkg::pix_to_pv(v);
      end
    end
    return r;
  endfunction

  // Driver: moves the input side at the falling edge. A request stays up with
  // its payload unchanged until the block takes it; a new one is loaded only
  // once the previous one was taken or the channel was idle.
  always @(negedge clk) begin : driver
    aer_req_t nxt;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_hs) begin
      if (aer_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = aer_req_q.pop_front();
        in_valid <= 1'b1;
        in_aer_word <= nxt.word;
        in_packet_end <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: samples both channels at the rising edge. A result is checked
  // before the request of the same edge is decoded, since a result always
  // belongs to an earlier request.
  always @(posedge clk) begin : monitor
    aer_eda_pkg::result_t got;
    aer_eda_pkg::result_t want;
    if (!rst_n) begin
      in_hs <= 1'b0;
    end else begin
      in_hs <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.word_kind = aer_eda_pkg::word_kind_t'(out_word_kind);
        got.x_coord = out_x_coord;
        got.y_coord = out_y_coord;
        got.is_on = out_is_on;
        got.event_time = out_event_time;
        got.accepted = out_accepted;
        got.pixel_value = out_pixel_value;
        got.ends_packet = out_ends_packet;
        if (decoded_q.size() == 0) begin
          error_count++;
          if (shown_errors < SHOW_LIMIT) begin
            shown_errors++;
            $display("%0t ns: result arrived with no request outstanding", $realtime);
          end
        end else begin
          want = decoded_q.pop_front();
          checked_results++;
          if (got.word_kind !== want.word_kind || got.x_coord !== want.x_coord ||
              got.y_coord !== want.y_coord || got.is_on !== want.is_on ||
              got.event_time !== want.event_time || got.accepted !== want.accepted ||
              got.pixel_value !== want.pixel_value ||
              got.ends_packet !== want.ends_packet) begin
            error_count++;
            if (shown_errors < SHOW_LIMIT) begin
              shown_errors++;
              $display("%0t ns: result %0d differs", $realtime, checked_results);
              $display("  expected kind=%0d x=%0d y=%0d on=%b time=%h acc=%b pix=%0d end=%b",
                       want.word_kind, want.x_coord, want.y_coord, want.is_on,
                       want.event_time, want.accepted, want.pixel_value, want.ends_packet);
              $display("  actual   kind=%0d x=%0d y=%0d on=%b time=%h acc=%b pix=%0d end=%b",
                       got.word_kind, got.x_coord, got.y_coord, got.is_on,
                       got.event_time, got.accepted, got.pixel_value, got.ends_packet);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        decoded_q.insert(decoded_q.size(), decode_word(in_aer_word, in_packet_end));
        taken_reqs++;
      end
    end
  end

  task automatic queue_word(input logic [31:0] w, input logic last);
    aer_req_t r;
    r.word = w;
    r.last = last;
    aer_req_q.insert(aer_req_q.size(), r);
    queued_reqs++;
  endtask

  // Builds an address-event word for pixel (px,py); the timestamp and the
  // ignored bit 15 are random.
  function automatic logic [31:0] pixel_word(input logic [6:0] px, input logic [6:0] py,
                                             input logic pol);
    return {2'b00, 14'($urandom), 1'($urandom), py, ~px, pol};
  endfunction

  // Random traffic. Most words are address events, many of them aimed at a
  // handful of pixels so that counters build up and the stuck pixel shows up
  // often; the rest are wraps, resets and words with both top bits set.
  task automatic queue_random(input int count);
    int pick;
    logic [31:0] w;
    logic [6:0] px;
    logic [6:0] py;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        w = $urandom | 32'h8000_0000;
      end else if (pick < 10) begin
        w = ($urandom & 32'h7FFF_FFFF) | 32'h4000_0000;
      end else if (pick < 30) begin
        w = $urandom & 32'h3FFF_FFFF;
      end else begin
        case ($urandom_range(5))
          0: begin
            px = 7'd127;
            py = 7'd0;
          end
          1: begin
            px = 7'd0;
            py = 7'd0;
          end
          2: begin
            px = 7'd0;
            py = 7'd127;
          end
          3: begin
            px = 7'd127;
            py = 7'd127;
          end
          4: begin
            px = 7'd126;
            py = 7'd0;
          end
          default: begin
            px = 7'd3;
            py = 7'd5;
          end
        endcase
        w = pixel_word(px, py, 1'($urandom));
      end
      queue_word(w, $urandom_range(3) == 0);
    end
  endtask

  // Waits at falling edges until every queued request was taken and every
  // decoded result has come out, then steps to a rising edge so that the
  // caller changes shared settings away from the driver's edge.
  task automatic drain;
    do begin
      @(negedge clk);
    end while (taken_reqs != queued_reqs || decoded_q.size() != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    for (int i = 0; i < aer_eda_pkg::FRAME_CELLS; i++) begin
      frame_count[i] = '0;
    end

    // Synchronous reset, released at a falling edge. The block
    // then clears its frame store with in_ready low; the driver just waits.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles 36% of cycles, receiver 55%.
    send_idle_pct = 36;
    recv_idle_pct = 55;

    // Directed requests: stuck pixel both polarities, field extremes, the
    // corner pixels, wrap and reset alone and combined, and end marks.
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'h0000_0001, 1'b1);
    queue_word(32'h3FFF_FFFF, 1'b0);
    queue_word(32'h3FFF_7FFE, 1'b1);
    queue_word(32'h0000_80FF, 1'b0);
    queue_word(32'h0000_7F01, 1'b0);
    queue_word(32'h8000_0000, 1'b1);
    queue_word(32'h1234_0A55, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word(32'h1234_0A54, 1'b1);
    queue_word(32'h4000_0000, 1'b0);
    queue_word(32'h0001_0000, 1'b0);
    queue_word(32'h7FFF_FFFF, 1'b1);
    queue_word(32'hC000_0000, 1'b0);
    queue_word(32'hBFFF_FFFF, 1'b0);
    queue_word(32'h2AAA_5554, 1'b1);
    queue_word(32'h1555_2AAB, 1'b0);
    queue_word(32'h0000_0002, 1'b0);
    queue_word(32'h0000_0100, 1'b1);
    queue_word(32'h4123_4567, 1'b0);
    queue_word(32'h0000_0000, 1'b1);
    queue_random(600);
    drain();

    // Phase two: the idle chances swap sides.
    send_idle_pct = 55;
    recv_idle_pct = 36;
    queue_random(600);
    drain();

    // Phase three: no idling, random traffic back to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(200);

    // Wait for the last results, with a limit, then wait on so
    // that any stray result would still be caught.
    n = 0;
    while ((taken_reqs != queued_reqs || decoded_q.size() != 0) && n < DRAIN_CYCLES) begin
      @(negedge clk);
      n++;
    end
    repeat (20) @(negedge clk);
    if (taken_reqs != queued_reqs) begin
      error_count += queued_reqs - taken_reqs;
      $display("%0d requests were never taken", queued_reqs - taken_reqs);
    end
    if (decoded_q.size() != 0) begin
      error_count += decoded_q.size();
      $display("%0d expected results never arrived", decoded_q.size());
    end

    $display("Checked %0d results for %0d requests: %0d address events (%0d on the stuck pixel),",
             checked_results, taken_reqs, seen_addr, seen_stuck);
    $display("  %0d wraps, %0d resets, %0d clamped updates, %0d offset rollovers; %0d errors.",
             seen_wrap, seen_reset, seen_clamped, seen_rollover, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Run timed out with %0d of %0d requests taken", taken_reqs, queued_reqs);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aer_eda_pkg.sv
rtl/aer_eda_ram.sv
rtl/aer_event_decode_accumulate.sv
bench/tb_aer_event_decode_accumulate.sv
